@@ hdl/sfs_pkg.sv @@
// Sprite frame sequencer package: widths, command and mode codes, FSM states
// and the structs passed between the top level and the sequencer core.
// No dependencies.
package sfs_pkg;

  localparam int TIME_W = 24;   // dt and frame period width
  localparam int ACC_W  = 32;   // elapsed time accumulator width
  localparam int CNT_W  = 9;    // frame count and frame number width
  localparam int ALU_W  = 33;   // operand width of the shared add/sub unit
  localparam int REM_W  = 24;   // partial remainder width of the divider
  localparam int STEP_W = 6;    // iteration counter width
  localparam int BCNT_W = 11;   // ping-pong step counter width
  localparam int OUT_W  = 8;    // reported frame index width

  localparam logic [STEP_W-1:0] DIV_LAST   = STEP_W'(ALU_W - 1);
  localparam logic [STEP_W-1:0] MUL_LAST   = STEP_W'(CNT_W - 1);
  localparam logic [TIME_W-1:0] PERIOD_RST = TIME_W'(1000);

  typedef enum logic [2:0] {
    FN_TICK    = 3'd0,
    FN_RESTART = 3'd1,
    FN_PAUSE   = 3'd2,
    FN_RESUME  = 3'd3,
    FN_RESET   = 3'd4
  } func_t;

  typedef enum logic [1:0] {
    MODE_LOOP     = 2'd0,
    MODE_ONESHOT  = 2'd1,
    MODE_HOLD     = 2'd2,
    MODE_PINGPONG = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    CFG_FRAME_COUNT  = 2'd0,
    CFG_PLAY_MODE    = 2'd1,
    CFG_FRAME_PERIOD = 2'd2
  } cfg_idx_t;

  typedef enum logic {
    ALU_ADD = 1'b0,
    ALU_SUB = 1'b1
  } alu_op_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_BRANCH,
    ST_MUL,
    ST_SUB,
    ST_FIN,
    ST_BOUNCE,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic [CNT_W-1:0]  count;    // clamped frame count
    mode_t             mode;
    logic [TIME_W-1:0] period;   // never zero
  } cfg_t;

  typedef struct packed {
    logic busy;
    logic res_valid;
  } core_stat_t;

  typedef struct packed {
    logic [OUT_W-1:0] frame_index;
    logic             finished;
    logic             paused;
  } core_res_t;

endpackage

@@ hdl/sfs_alu.sv @@
// Shared add/subtract unit of the sprite frame sequencer.
// Carry (add) or borrow (subtract) comes out on the top bit.
// Depends on sfs_pkg.
module sfs_alu
  import sfs_pkg::*;
(
  input  alu_op_t          op,
  input  logic [ALU_W-1:0] a,
  input  logic [ALU_W-1:0] b,
  output logic [ALU_W:0]   res
);

  always_comb begin
    unique case (op)
      ALU_ADD: res = {1'b0, a} + {1'b0, b};
      ALU_SUB: res = {1'b0, a} - {1'b0, b};
    endcase
  end

endmodule

@@ hdl/sfs_core.sv @@
// Sequencer core: playback state and the small FSM that drives the shared
// add/sub unit through divide and multiply sequences, plus ping-pong stepping.
// Depends on sfs_pkg and sfs_alu.
module sfs_core
  import sfs_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [2:0]        func,
  input  logic [TIME_W-1:0] dt,
  input  cfg_t              cfg,
  input  logic              ack,
  output core_stat_t        stat,
  output core_res_t         res
);

  state_t             state_r, state_nxt;
  logic [ACC_W-1:0]   elapsed_r, elapsed_nxt;
  logic [CNT_W-1:0]   frame_r, frame_nxt;
  logic               dir_r, dir_nxt;
  logic               done_r, done_nxt;
  logic               pause_r, pause_nxt;
  logic               sel_r, sel_nxt;
  logic [ACC_W-1:0]   sum_r, sum_nxt;
  logic [ALU_W-1:0]   dq_r, dq_nxt;
  logic [REM_W-1:0]   pr_r, pr_nxt;
  logic [REM_W-1:0]   div_r, div_nxt;
  logic               first_r, first_nxt;
  logic [STEP_W-1:0]  step_r, step_nxt;
  logic [CNT_W-1:0]   mul_r, mul_nxt;
  logic [BCNT_W-1:0]  bcnt_r, bcnt_nxt;

  alu_op_t            alu_op;
  logic [ALU_W-1:0]   alu_a;
  logic [ALU_W-1:0]   alu_b;
  logic [ALU_W:0]     alu_res;

  logic               tick_ok;
  logic [ACC_W-1:0]   sum_sat;
  logic [REM_W:0]     trial_a;
  logic [CNT_W-1:0]   count_m1;
  logic [CNT_W-1:0]   room;
  logic               n_zero;
  logic               n_le_room;
  logic [CNT_W:0]     lead;
  logic [CNT_W:0]     cycle;
  logic               n_le_lead;
  logic               b_dir0;
  logic [CNT_W:0]     b_step;
  logic               b_dir;

  sfs_alu u_alu (
    .op  (alu_op),
    .a   (alu_a),
    .b   (alu_b),
    .res (alu_res)
  );

  assign tick_ok   = sel_r && !pause_r && !done_r && (cfg.count != '0);
  assign sum_sat   = alu_res[ACC_W] ? '1 : alu_res[ACC_W-1:0];
  assign trial_a   = {pr_r, dq_r[ALU_W-1]};
  assign count_m1  = cfg.count - 1'b1;
  assign room      = (frame_r < count_m1) ? (count_m1 - frame_r) : '0;
  assign n_zero    = (dq_r == '0);
  assign n_le_room = (dq_r[ALU_W-1:CNT_W] == '0) && (dq_r[CNT_W-1:0] <= room);
  assign lead      = {1'b0, cfg.count} + 1'b1;
  assign cycle     = {count_m1, 1'b0};
  assign n_le_lead = (dq_r[ALU_W-1:CNT_W+1] == '0) && (dq_r[CNT_W:0] <= lead);

  // One ping-pong step: turn at frame zero first, move, then turn at the ends.
  assign b_dir0 = dir_r && (frame_r != '0);
  assign b_step = b_dir0 ? ({1'b0, frame_r} - 1'b1) : ({1'b0, frame_r} + 1'b1);
  always_comb begin
    if (b_step >= {1'b0, count_m1}) begin
      b_dir = 1'b1;
    end else if (b_step == '0) begin
      b_dir = 1'b0;
    end else begin
      b_dir = b_dir0;
    end
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          if ((func_t'(func) == FN_TICK) && tick_ok) begin
            state_nxt = ST_DIV;
          end else begin
            state_nxt = ST_DONE;
          end
        end
      end
      ST_DIV: begin
        if (step_r == '0) begin
          state_nxt = first_r ? ST_BRANCH : ST_FIN;
        end
      end
      ST_BRANCH: begin
        if (n_zero) begin
          state_nxt = ST_DONE;
        end else begin
          case (cfg.mode) inside
            MODE_LOOP: state_nxt = ST_DIV;
            MODE_ONESHOT, MODE_HOLD: state_nxt = n_le_room ? ST_DONE : ST_MUL;
            default: begin
              if (cfg.count == CNT_W'(1)) begin
                state_nxt = ST_DONE;
              end else if (n_le_lead) begin
                state_nxt = ST_BOUNCE;
              end else begin
                state_nxt = ST_DIV;
              end
            end
          endcase
        end
      end
      ST_MUL: begin
        if (step_r == '0) begin
          state_nxt = ST_SUB;
        end
      end
      ST_SUB: state_nxt = ST_DONE;
      ST_FIN: state_nxt = (cfg.mode == MODE_LOOP) ? ST_DONE : ST_BOUNCE;
      ST_BOUNCE: begin
        if (bcnt_r == '0) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (ack) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Datapath and shared unit control
  always_comb begin
    elapsed_nxt = elapsed_r;
    frame_nxt   = frame_r;
    dir_nxt     = dir_r;
    done_nxt    = done_r;
    pause_nxt   = pause_r;
    sel_nxt     = sel_r;
    sum_nxt     = sum_r;
    dq_nxt      = dq_r;
    pr_nxt      = pr_r;
    div_nxt     = div_r;
    first_nxt   = first_r;
    step_nxt    = step_r;
    mul_nxt     = mul_r;
    bcnt_nxt    = bcnt_r;
    alu_op      = ALU_ADD;
    alu_a       = '0;
    alu_b       = '0;

    unique case (state_r)
      ST_IDLE: begin
        alu_a = ALU_W'(elapsed_r);
        alu_b = ALU_W'(dt);
        if (start) begin
          unique case (func_t'(func))
            FN_TICK: begin
              if (tick_ok) begin
                sum_nxt   = sum_sat;
                dq_nxt    = ALU_W'(sum_sat);
                pr_nxt    = '0;
                div_nxt   = cfg.period;
                step_nxt  = DIV_LAST;
                first_nxt = 1'b1;
              end
            end
            FN_RESTART: begin
              sel_nxt     = 1'b1;
              elapsed_nxt = '0;
              frame_nxt   = '0;
              dir_nxt     = 1'b0;
              done_nxt    = 1'b0;
            end
            FN_PAUSE:  pause_nxt = 1'b1;
            FN_RESUME: pause_nxt = 1'b0;
            FN_RESET: begin
              elapsed_nxt = '0;
              frame_nxt   = '0;
              dir_nxt     = 1'b0;
              done_nxt    = 1'b0;
              pause_nxt   = 1'b0;
            end
            default: ;
          endcase
        end
      end
      ST_DIV: begin
        // restoring divide, one quotient bit per cycle
        alu_op   = ALU_SUB;
        alu_a    = ALU_W'(trial_a);
        alu_b    = ALU_W'(div_r);
        pr_nxt   = alu_res[ALU_W] ? trial_a[REM_W-1:0] : alu_res[REM_W-1:0];
        dq_nxt   = {dq_r[ALU_W-2:0], ~alu_res[ALU_W]};
        step_nxt = step_r - 1'b1;
      end
      ST_BRANCH: begin
        // dq_r holds the number of whole periods, pr_r the leftover time
        elapsed_nxt = n_zero ? sum_r : ACC_W'(pr_r);
        if (cfg.mode == MODE_LOOP) begin
          alu_op = ALU_ADD;
          alu_a  = ALU_W'(frame_r);
          alu_b  = dq_r;
        end else begin
          alu_op = ALU_SUB;
          alu_a  = dq_r;
          alu_b  = ALU_W'(lead);
        end
        if (!n_zero) begin
          case (cfg.mode) inside
            MODE_LOOP: begin
              dq_nxt    = alu_res[ALU_W-1:0];
              pr_nxt    = '0;
              div_nxt   = REM_W'(cfg.count);
              step_nxt  = DIV_LAST;
              first_nxt = 1'b0;
            end
            MODE_ONESHOT, MODE_HOLD: begin
              if (n_le_room) begin
                frame_nxt = frame_r + dq_r[CNT_W-1:0];
              end else begin
                // stop at the last frame; leftover is sum - (room+1)*period
                frame_nxt = frame_r + room;
                mul_nxt   = room + 1'b1;
                dq_nxt    = '0;
                step_nxt  = MUL_LAST;
              end
            end
            default: begin
              if (cfg.count == CNT_W'(1)) begin
                frame_nxt = '0;
                dir_nxt   = 1'b0;
              end else if (n_le_lead) begin
                bcnt_nxt = BCNT_W'(dq_r[CNT_W:0]);
              end else begin
                // reduce the steps past the lead-in by the bounce period
                dq_nxt    = alu_res[ALU_W-1:0];
                pr_nxt    = '0;
                div_nxt   = REM_W'(cycle);
                step_nxt  = DIV_LAST;
                first_nxt = 1'b0;
              end
            end
          endcase
        end
      end
      ST_MUL: begin
        // shift-add, multiplier MSB first
        alu_op   = ALU_ADD;
        alu_a    = {dq_r[ALU_W-2:0], 1'b0};
        alu_b    = mul_r[CNT_W-1] ? ALU_W'(cfg.period) : '0;
        dq_nxt   = alu_res[ALU_W-1:0];
        mul_nxt  = {mul_r[CNT_W-2:0], 1'b0};
        step_nxt = step_r - 1'b1;
      end
      ST_SUB: begin
        alu_op      = ALU_SUB;
        alu_a       = ALU_W'(sum_r);
        alu_b       = dq_r;
        elapsed_nxt = alu_res[ACC_W-1:0];
        if (cfg.mode == MODE_ONESHOT) begin
          done_nxt = 1'b1;
        end else begin
          pause_nxt = 1'b1;
        end
      end
      ST_FIN: begin
        if (cfg.mode == MODE_LOOP) begin
          frame_nxt = pr_r[CNT_W-1:0];
        end else begin
          bcnt_nxt = BCNT_W'(lead) + BCNT_W'(pr_r[CNT_W:0]);
        end
      end
      ST_BOUNCE: begin
        if (bcnt_r != '0) begin
          frame_nxt = b_step[CNT_W-1:0];
          dir_nxt   = b_dir;
          bcnt_nxt  = bcnt_r - 1'b1;
        end
      end
      ST_DONE: ;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      elapsed_r <= '0;
      frame_r   <= '0;
      dir_r     <= 1'b0;
      done_r    <= 1'b0;
      pause_r   <= 1'b0;
      sel_r     <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      elapsed_r <= elapsed_nxt;
      frame_r   <= frame_nxt;
      dir_r     <= dir_nxt;
      done_r    <= done_nxt;
      pause_r   <= pause_nxt;
      sel_r     <= sel_nxt;
    end
  end

  always_ff @(posedge clk) begin
    sum_r   <= sum_nxt;
    dq_r    <= dq_nxt;
    pr_r    <= pr_nxt;
    div_r   <= div_nxt;
    first_r <= first_nxt;
    step_r  <= step_nxt;
    mul_r   <= mul_nxt;
    bcnt_r  <= bcnt_nxt;
  end

  assign stat.busy        = (state_r != ST_IDLE);
  assign stat.res_valid   = (state_r == ST_DONE);
  assign res.frame_index  = frame_r[OUT_W-1:0];
  assign res.finished     = done_r;
  assign res.paused       = pause_r;

endmodule

@@ hdl/sprite_frame_sequencer.sv @@
// Sprite frame sequencer, one transaction at a time. Commands and ignored ticks go
// straight to the result; a tick runs a 33-step divide by the period on the shared
// add/sub unit, loop adds a divide by the frame count, one-shot/hold past the end
// adds a multiply and subtract, ping-pong steps frame by frame after a divide by
// the bounce period if the steps are reduced. in_stall is high until the result
// moves to the output register. rst_n (sync) clears control and config state.
module sprite_frame_sequencer
  import sfs_pkg::*;
#(
  parameter int MAX_FRAMES = 256,
  parameter int TIME_BITS  = 24
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [2:0]        in_func,
  input  logic [TIME_W-1:0] in_dt,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [OUT_W-1:0]  out_frame_index,
  output logic              out_finished,
  output logic              out_paused,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [1:0]        cfg_index,
  input  logic [TIME_W-1:0] cfg_data
);

  localparam logic [TIME_W-1:0] TIME_MASK = (TIME_BITS >= TIME_W) ? '1 :
                                            TIME_W'((64'd1 << TIME_BITS) - 64'd1);
  localparam int                CNT_MAX   = (1 << CNT_W) - 1;
  localparam logic [CNT_W-1:0]  CNT_CLAMP = CNT_W'((MAX_FRAMES < CNT_MAX) ?
                                                   MAX_FRAMES : CNT_MAX);

  logic [CNT_W-1:0]  frame_count_r;
  mode_t             play_mode_r;
  logic [TIME_W-1:0] frame_period_r;
  cfg_t              cfg;
  core_stat_t        core_stat;
  core_res_t         core_res;
  logic              in_take;
  logic              out_load;
  logic              out_valid_r, out_valid_nxt;
  logic [OUT_W-1:0]  out_frame_index_r;
  logic              out_finished_r;
  logic              out_paused_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_count_r  <= '0;
      play_mode_r    <= MODE_LOOP;
      frame_period_r <= PERIOD_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_FRAME_COUNT:  frame_count_r  <= cfg_data[CNT_W-1:0];
        CFG_PLAY_MODE:    play_mode_r    <= mode_t'(cfg_data[1:0]);
        CFG_FRAME_PERIOD: frame_period_r <= cfg_data & TIME_MASK;
        default: ;
      endcase
    end
  end

  // clamp the count, treat a zero period as one
  assign cfg.count  = (frame_count_r > CNT_CLAMP) ? CNT_CLAMP : frame_count_r;
  assign cfg.mode   = play_mode_r;
  assign cfg.period = (frame_period_r == '0) ? TIME_W'(1) : frame_period_r;

  assign in_stall = core_stat.busy;
  assign in_take  = in_valid && !in_stall;

  sfs_core u_core (
    .clk   (clk),
    .rst_n (rst_n),
    .start (in_take),
    .func  (in_func),
    .dt    (in_dt & TIME_MASK),
    .cfg   (cfg),
    .ack   (out_load),
    .stat  (core_stat),
    .res   (core_res)
  );

  // move the result out once the output register is free or being drained
  assign out_load      = core_stat.res_valid && (!out_valid_r || !out_stall);
  assign out_valid_nxt = out_load ? 1'b1 : (out_valid_r && out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_frame_index_r <= core_res.frame_index;
      out_finished_r    <= core_res.finished;
      out_paused_r      <= core_res.paused;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_frame_index = out_frame_index_r;
  assign out_finished    = out_finished_r;
  assign out_paused      = out_paused_r;

`ifndef NO_ASSERTIONS
  a_busy_after_take: assert property (@(posedge clk) disable iff (!rst_n)
    in_take |=> in_stall)
    else $error("input not stalled after a transaction");

  a_out_from_core: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(core_stat.res_valid))
    else $error("output valid without a finished result");

  a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
    (core_stat.res_valid && out_valid && out_stall) |=> core_stat.res_valid)
    else $error("result dropped while output stalled");
`endif

endmodule
